// ----- sv/text_console_writer_unit_defines.svh -----
// assertion macros shared by the console writer modules
// depends on clk and rst being visible in the module that uses them
`ifndef TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TCW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("console writer check failed");

// next-cycle implication, checked out of reset
`define TCW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("console writer check failed");

`endif

// ----- sv/tcw_pkg.sv -----
// shared constants, codes and controller/datapath interface types
// for the text console writer; no dependencies
package tcw_pkg;

  // screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int COPY_COUNT = CELL_COUNT - COLUMNS;

  // field widths
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = 11;
  localparam int ATTR_W = 8;
  localparam int CHAR_W = 8;
  localparam int WORD_W = 16;

  // attribute after reset
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd32;

  // control characters and blank
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_BLANK   = 8'd32;
  localparam int TAB_STOP = 4;

  // operation codes
  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  // what a sweep over the store writes
  typedef enum logic [1:0] {
    SW_ZERO   = 2'd0,
    SW_BLANK  = 2'd1,
    SW_SCROLL = 2'd2
  } sweep_kind_t;

  // controller to datapath
  typedef struct packed {
    logic        capture;
    logic        exec;
    logic        sweep_start;
    sweep_kind_t sweep_kind;
    logic        sweep_step;
    logic        load_out;
  } tcw_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic put_scroll;
    logic sweep_last;
    logic out_free;
  } tcw_stat_t;

endpackage

// ----- sv/tcw_datapath.sv -----
// datapath of the text console writer: screen store, cursor, attribute,
// sweep counter and output register; uses tcw_pkg and the defines header
`include "text_console_writer_unit_defines.svh"

module tcw_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write_enable,
  input  logic [tcw_pkg::ATTR_W-1:0]   cfg_write_data,
  input  logic [1:0]                   operation,
  input  logic [tcw_pkg::CHAR_W-1:0]   character,
  input  logic [tcw_pkg::ADDR_W-1:0]   cell_index,
  input  tcw_pkg::tcw_cmd_t            cmd,
  output tcw_pkg::tcw_stat_t           stat,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [tcw_pkg::COL_W-1:0]    cursor_column,
  output logic [tcw_pkg::ROW_W-1:0]    cursor_row,
  output logic [tcw_pkg::WORD_W-1:0]   cell_word,
  output logic                         scrolled
);

  localparam int CW = tcw_pkg::COL_W + 1;
  localparam int RW = tcw_pkg::ROW_W + 1;

  logic [tcw_pkg::ATTR_W-1:0] attribute;
  tcw_pkg::op_t               op_q;
  logic [tcw_pkg::CHAR_W-1:0] ch_q;
  logic                       idx_ok;
  logic [tcw_pkg::COL_W-1:0]  col;
  logic [tcw_pkg::ROW_W-1:0]  row;
  logic                       scroll_q;

  logic [tcw_pkg::WORD_W-1:0] mem [tcw_pkg::CELL_COUNT];
  logic [tcw_pkg::WORD_W-1:0] rd_data;
  logic                       rd_en;
  logic [tcw_pkg::ADDR_W-1:0] rd_addr;

  logic [tcw_pkg::ADDR_W-1:0] sw;
  tcw_pkg::sweep_kind_t       kind;
  logic                       wr_pend;
  logic [tcw_pkg::ADDR_W-1:0] wr_addr;
  logic                       wr_copy;
  logic                       copy;
  logic [tcw_pkg::ADDR_W-1:0] sweep_rd_addr;
  logic [tcw_pkg::WORD_W-1:0] fill_word;

  logic [CW-1:0]              col_ext;
  logic [CW-1:0]              col_mv;
  logic [RW-1:0]              row_mv;
  logic                       printable;
  logic                       need_scroll;
  logic [tcw_pkg::COL_W-1:0]  col_put;
  logic [tcw_pkg::ROW_W-1:0]  row_put;
  logic                       put_write;
  logic [tcw_pkg::ADDR_W-1:0] put_addr;

  logic [tcw_pkg::COL_W-1:0]  col_nx;
  logic [tcw_pkg::ROW_W-1:0]  row_nx;
  logic                       scr_nx;
  logic [tcw_pkg::COL_W-1:0]  col_cur;
  logic [tcw_pkg::ROW_W-1:0]  row_cur;
  logic                       scr_cur;
  logic [tcw_pkg::WORD_W-1:0] word_cur;

  // cursor move for a put
  always_comb begin
    col_ext   = {1'b0, col};
    col_mv    = col_ext + CW'(1);
    row_mv    = {1'b0, row};
    printable = 1'b0;
    case (ch_q)
      tcw_pkg::CH_NEWLINE: begin
        col_mv = '0;
        row_mv = {1'b0, row} + RW'(1);
      end
      tcw_pkg::CH_RETURN: begin
        col_mv = '0;
      end
      tcw_pkg::CH_TAB: begin
        col_mv = (col_ext + CW'(tcw_pkg::TAB_STOP)) & ~(CW'(tcw_pkg::TAB_STOP - 1));
      end
      default: begin
        printable = 1'b1;
      end
    endcase
    // wrap at the right edge
    if (col_mv >= CW'(tcw_pkg::COLUMNS)) begin
      col_mv = '0;
      row_mv = row_mv + RW'(1);
    end
    need_scroll = (row_mv >= RW'(tcw_pkg::ROWS));
    col_put     = col_mv[tcw_pkg::COL_W-1:0];
    row_put     = need_scroll ? tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)
                              : row_mv[tcw_pkg::ROW_W-1:0];
  end

  assign put_write = cmd.exec && (op_q == tcw_pkg::OP_PUT) && printable;
  assign put_addr  = tcw_pkg::ADDR_W'(row * tcw_pkg::COLUMNS) + tcw_pkg::ADDR_W'(col);

  // cursor after the operation
  always_comb begin
    col_nx = col;
    row_nx = row;
    scr_nx = 1'b0;
    case (op_q)
      tcw_pkg::OP_PUT: begin
        col_nx = col_put;
        row_nx = row_put;
        scr_nx = need_scroll;
      end
      tcw_pkg::OP_CLEAR: begin
        col_nx = '0;
        row_nx = '0;
      end
      default: begin
        col_nx = col;
        row_nx = row;
      end
    endcase
  end

  assign col_cur  = cmd.exec ? col_nx : col;
  assign row_cur  = cmd.exec ? row_nx : row;
  assign scr_cur  = cmd.exec ? scr_nx : scroll_q;
  assign word_cur = ((op_q == tcw_pkg::OP_READ) && idx_ok) ? rd_data : '0;

  // sweep element: copy from the row below or fill
  assign copy          = (kind == tcw_pkg::SW_SCROLL) && (sw < tcw_pkg::ADDR_W'(tcw_pkg::COPY_COUNT));
  assign sweep_rd_addr = sw + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
  assign fill_word     = (kind == tcw_pkg::SW_ZERO) ? '0 : {attribute, tcw_pkg::CH_BLANK};

  // read port: request cell or scroll source
  assign rd_en   = cmd.capture ? (cell_index < tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT))
                               : (cmd.sweep_step && copy);
  assign rd_addr = cmd.capture ? cell_index : sweep_rd_addr;

  // screen store, one write and one read a cycle
  always_ff @(posedge clk) begin
    if (wr_pend) begin
      mem[wr_addr] <= wr_copy ? rd_data : fill_word;
    end else if (put_write) begin
      mem[put_addr] <= {attribute, ch_q};
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // request capture and sweep write stage
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= tcw_pkg::op_t'(operation);
      ch_q   <= character;
      idx_ok <= (cell_index < tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT));
    end
    wr_addr <= sw;
    wr_copy <= copy;
    if (out_valid == 1'b0 || out_ready) begin
      if (cmd.load_out) begin
        cursor_column <= col_cur;
        cursor_row    <= row_cur;
        cell_word     <= word_cur;
        scrolled      <= scr_cur;
      end
    end
    if (cmd.exec) begin
      scroll_q <= scr_nx;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      attribute <= tcw_pkg::ATTR_RESET;
      col       <= '0;
      row       <= '0;
      sw        <= '0;
      kind      <= tcw_pkg::SW_ZERO;
      wr_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write_enable) begin
        attribute <= cfg_write_data;
      end
      if (cmd.exec) begin
        col <= col_nx;
        row <= row_nx;
      end
      if (cmd.sweep_start) begin
        sw   <= '0;
        kind <= cmd.sweep_kind;
      end else if (cmd.sweep_step) begin
        sw <= sw + tcw_pkg::ADDR_W'(1);
      end
      wr_pend <= cmd.sweep_step;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // status to the controller
  always_comb begin
    stat.op         = op_q;
    stat.put_scroll = need_scroll;
    stat.sweep_last = (sw == tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1));
    stat.out_free   = !out_valid || out_ready;
  end

  // checks
  `TCW_ASSERT_NOW(a_cursor_range, 1'b1, (col < tcw_pkg::COL_W'(tcw_pkg::COLUMNS)) && (row < tcw_pkg::ROW_W'(tcw_pkg::ROWS)))
  `TCW_ASSERT_NOW(a_one_writer, wr_pend, !put_write)
  `TCW_ASSERT_NEXT(a_step_writes, cmd.sweep_step && !rst, wr_pend)

endmodule

// ----- sv/tcw_controller.sv -----
// controller of the text console writer: sequences request capture,
// execution, store sweeps and result hand-off; uses tcw_pkg and the defines header
`include "text_console_writer_unit_defines.svh"

module tcw_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tcw_pkg::tcw_stat_t stat,
  output tcw_pkg::tcw_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_SWEEP,
    S_TAIL,
    S_IDLE,
    S_EXEC,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   boot;
  logic   boot_next;

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    boot_next  = boot;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.op == tcw_pkg::OP_CLEAR) begin
          cmd.sweep_start = 1'b1;
          cmd.sweep_kind  = tcw_pkg::SW_BLANK;
          state_next      = S_SWEEP;
        end else if (stat.op == tcw_pkg::OP_PUT && stat.put_scroll) begin
          cmd.sweep_start = 1'b1;
          cmd.sweep_kind  = tcw_pkg::SW_SCROLL;
          state_next      = S_SWEEP;
        end else if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        // last sweep write lands this cycle
        if (boot) begin
          boot_next  = 1'b0;
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register; reset starts the zeroing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      boot  <= 1'b1;
    end else begin
      state <= state_next;
      boot  <= boot_next;
    end
  end

  // checks
  `TCW_ASSERT_NOW(a_load_when_free, cmd.load_out, stat.out_free)
  `TCW_ASSERT_NOW(a_sweep_from_exec, cmd.sweep_start, cmd.exec)
  `TCW_ASSERT_NEXT(a_capture_then_exec, cmd.capture, cmd.exec)

endmodule

// ----- sv/text_console_writer_unit.sv -----
// Text console writer: an 80 x 25 screen store of 16-bit cells (attribute
// high, character low) with a cursor. Each request puts a character, clears
// the screen, reads one cell or, with an unused code, changes nothing, and
// gives one result with the cursor after the operation. A put, a read or an
// unused code occupies the block for a capture state, then an execute state,
// where its result is loaded into the output register if that is free. A
// put that scrolls and a clear also run a sweep, in which the single write
// port of the store walks every cell once, copying rows up or writing
// blanks. After reset a clearing pass zeroes the store and in_ready stays
// low until it ends; attribute writes are taken meanwhile. The result sits
// in an output register, so a request may be accepted and executed while
// the previous result still waits; its own result is then held back, and
// in_ready stays low, until the previous one is taken.

module text_console_writer_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write_enable,
  input  logic [tcw_pkg::ATTR_W-1:0]  cfg_write_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  operation,
  input  logic [tcw_pkg::CHAR_W-1:0]  character,
  input  logic [tcw_pkg::ADDR_W-1:0]  cell_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tcw_pkg::COL_W-1:0]   cursor_column,
  output logic [tcw_pkg::ROW_W-1:0]   cursor_row,
  output logic [tcw_pkg::WORD_W-1:0]  cell_word,
  output logic                        scrolled
);

  tcw_pkg::tcw_cmd_t  cmd;
  tcw_pkg::tcw_stat_t stat;

  // sequencing
  tcw_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // store, cursor and result register
  tcw_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .operation        (operation),
    .character        (character),
    .cell_index       (cell_index),
    .cmd              (cmd),
    .stat             (stat),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .cursor_column    (cursor_column),
    .cursor_row       (cursor_row),
    .cell_word        (cell_word),
    .scrolled         (scrolled)
  );

endmodule

// ----- bench/text_console_writer_unit_tb.sv -----
// testbench for the text console writer: directed and random requests, a
// screen predictor in a small scoreboard class, and random idling on both sides
// depends on tcw_pkg and text_console_writer_unit
module text_console_writer_unit_tb;

  // code with no operation behind it
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 10000000;
  localparam int PHASE_REQUESTS = 357;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [tcw_pkg::COL_W-1:0]  col;
    logic [tcw_pkg::ROW_W-1:0]  row;
    logic [tcw_pkg::WORD_W-1:0] word;
    logic                       scroll;
  } console_result_t;

  // screen predictor and queue of awaited results
  class console_scoreboard;
    logic [tcw_pkg::WORD_W-1:0] cells [tcw_pkg::CELL_COUNT];
    int unsigned                cursor_col;
    int unsigned                cursor_line;
    logic [tcw_pkg::ATTR_W-1:0] attr;
    console_result_t            awaited [$];
    int failures;
    int requests;
    int results;
    int scrolls;
    int clears;
    int reads;
    int attr_writes;

    function void clear_state();
      foreach (cells[i]) cells[i] = '0;
      cursor_col = 0;
      cursor_line = 0;
      attr = tcw_pkg::ATTR_RESET;
    endfunction

    function void set_attribute(logic [tcw_pkg::ATTR_W-1:0] value);
      attr = value;
      attr_writes++;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // cursor movement, cell write and scroll for one put
    function bit put_char(logic [tcw_pkg::CHAR_W-1:0] ch);
      int unsigned pos;
      bit          moved_up;
      moved_up = 1'b0;
      if (ch == tcw_pkg::CH_NEWLINE) begin
        cursor_col = 0;
        cursor_line++;
      end else if (ch == tcw_pkg::CH_RETURN) begin
        cursor_col = 0;
      end else if (ch == tcw_pkg::CH_TAB) begin
        cursor_col = (cursor_col + tcw_pkg::TAB_STOP) & ~(tcw_pkg::TAB_STOP - 1);
      end else begin
        pos = cursor_line * tcw_pkg::COLUMNS + cursor_col;
        if (pos < tcw_pkg::CELL_COUNT) cells[pos] = {attr, ch};
        cursor_col++;
      end
      if (cursor_col >= tcw_pkg::COLUMNS) begin
        cursor_col = 0;
        cursor_line++;
      end
      if (cursor_line >= tcw_pkg::ROWS) begin
        for (int i = 0; i < tcw_pkg::COPY_COUNT; i++)
          cells[i] = cells[i + tcw_pkg::COLUMNS];
        for (int i = tcw_pkg::COPY_COUNT; i < tcw_pkg::CELL_COUNT; i++)
          cells[i] = {attr, tcw_pkg::CH_BLANK};
        cursor_line = tcw_pkg::ROWS - 1;
        moved_up = 1'b1;
      end
      return moved_up;
    endfunction

    function void note_request(logic [1:0] op, logic [tcw_pkg::CHAR_W-1:0] ch,
                               logic [tcw_pkg::ADDR_W-1:0] idx);
      console_result_t res;
      res = '0;
      requests++;
      case (op)
        tcw_pkg::OP_PUT: begin
          res.scroll = put_char(ch);
          if (res.scroll) scrolls++;
        end
        tcw_pkg::OP_CLEAR: begin
          foreach (cells[i]) cells[i] = {attr, tcw_pkg::CH_BLANK};
          cursor_col = 0;
          cursor_line = 0;
          clears++;
        end
        tcw_pkg::OP_READ: begin
          if (idx < tcw_pkg::CELL_COUNT) begin
            res.word = cells[idx];
            reads++;
          end
        end
        default: ;
      endcase
      res.col = cursor_col[tcw_pkg::COL_W-1:0];
      res.row = cursor_line[tcw_pkg::ROW_W-1:0];
      awaited.push_back(res);
    endfunction

    function void check_result(console_result_t got);
      console_result_t want;
      results++;
      if (awaited.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("unexpected result: col %0d row %0d word %h scrolled %0d",
                   got.col, got.row, got.word, got.scroll);
        return;
      end
      want = awaited.pop_front();
      if (want.col !== got.col || want.row !== got.row ||
          want.word !== got.word || want.scroll !== got.scroll) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("mismatch on result %0d: expected col %0d row %0d word %h scrolled %0d",
                   results, want.col, want.row, want.word, want.scroll,
                   "; got col %0d row %0d word %h scrolled %0d",
                   got.col, got.row, got.word, got.scroll);
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       cfg_write_enable;
  logic [tcw_pkg::ATTR_W-1:0] cfg_write_data;
  logic                       in_valid;
  logic                       in_ready;
  logic [1:0]                 operation;
  logic [tcw_pkg::CHAR_W-1:0] character;
  logic [tcw_pkg::ADDR_W-1:0] cell_index;
  logic                       out_valid;
  logic                       out_ready;
  logic [tcw_pkg::COL_W-1:0]  cursor_column;
  logic [tcw_pkg::ROW_W-1:0]  cursor_row;
  logic [tcw_pkg::WORD_W-1:0] cell_word;
  logic                       scrolled;

  console_scoreboard board;
  int send_idle_pct;
  int recv_stall_pct;
  int cycle_count = 0;

  text_console_writer_unit u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .operation        (operation),
    .character        (character),
    .cell_index       (cell_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .cursor_column    (cursor_column),
    .cursor_row       (cursor_row),
    .cell_word        (cell_word),
    .scrolled         (scrolled)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles with %0d results outstanding",
               cycle_count, board.pending());
      $display("FAILURE");
      $finish;
    end
  end

  // result side: check accepted results, then stall at random
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_result('{cursor_column, cursor_row, cell_word, scrolled});
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // one request, with an optional random gap before it
  task automatic send_request(input logic [1:0] op,
                              input logic [tcw_pkg::CHAR_W-1:0] ch,
                              input logic [tcw_pkg::ADDR_W-1:0] idx);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    character  <= ch;
    cell_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(op, ch, idx);
  endtask

  // mostly text with line breaks, reads near the cursor, rare clears
  task automatic send_random_request();
    int unsigned pick;
    int unsigned sub;
    logic [tcw_pkg::CHAR_W-1:0] ch;
    logic [tcw_pkg::ADDR_W-1:0] idx;
    pick = $urandom_range(999);
    sub  = $urandom_range(99);
    ch   = tcw_pkg::CHAR_W'($urandom_range(255));
    idx  = tcw_pkg::ADDR_W'($urandom_range(2047));
    if (pick < 4) begin
      send_request(tcw_pkg::OP_CLEAR, ch, idx);
    end else if (pick < 25) begin
      send_request(OP_UNUSED, ch, idx);
    end else if (pick < 330) begin
      if (sub < 50)
        idx = tcw_pkg::ADDR_W'(board.cursor_line * tcw_pkg::COLUMNS
                               + $urandom_range(tcw_pkg::COLUMNS - 1));
      else if (sub < 85)
        idx = tcw_pkg::ADDR_W'($urandom_range(tcw_pkg::CELL_COUNT - 1));
      else
        idx = tcw_pkg::ADDR_W'($urandom_range(2047, tcw_pkg::CELL_COUNT));
      send_request(tcw_pkg::OP_READ, ch, idx);
    end else begin
      if (sub < 15) ch = tcw_pkg::CH_NEWLINE;
      else if (sub < 19) ch = tcw_pkg::CH_RETURN;
      else if (sub < 25) ch = tcw_pkg::CH_TAB;
      send_request(tcw_pkg::OP_PUT, ch, idx);
    end
  endtask

  // wait until every result has come back
  task automatic wait_drained();
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // attribute write, only while the block is idle
  task automatic write_attribute(input logic [tcw_pkg::ATTR_W-1:0] value);
    cfg_write_enable <= 1'b1;
    cfg_write_data   <= value;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    board.set_attribute(value);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct,
                           input logic [tcw_pkg::ATTR_W-1:0] value);
    wait_drained();
    write_attribute(value);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (PHASE_REQUESTS) send_random_request();
    in_valid <= 1'b0;
  endtask

  initial begin
    board = new;
    board.clear_state();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst              <= 1'b1;
    cfg_write_enable <= 1'b0;
    cfg_write_data   <= '0;
    in_valid         <= 1'b0;
    operation        <= tcw_pkg::OP_PUT;
    character        <= '0;
    cell_index       <= '0;
    out_ready        <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: reset contents, range edges, unused code, controls, clear
    send_request(tcw_pkg::OP_READ, 8'h00, 11'd0);
    send_request(tcw_pkg::OP_READ, 8'hFF, 11'd1999);
    send_request(tcw_pkg::OP_READ, 8'h00, 11'd2000);
    send_request(tcw_pkg::OP_READ, 8'h00, 11'd2047);
    send_request(OP_UNUSED, 8'hFF, 11'd2047);
    send_request(tcw_pkg::OP_PUT, 8'h41, 11'd0);
    send_request(tcw_pkg::OP_PUT, 8'h00, 11'd0);
    send_request(tcw_pkg::OP_PUT, 8'hFF, 11'd0);
    send_request(tcw_pkg::OP_PUT, tcw_pkg::CH_TAB, 11'd0);
    send_request(tcw_pkg::OP_PUT, tcw_pkg::CH_TAB, 11'd0);
    send_request(tcw_pkg::OP_PUT, 8'h42, 11'd0);
    send_request(tcw_pkg::OP_PUT, tcw_pkg::CH_RETURN, 11'd0);
    send_request(tcw_pkg::OP_PUT, tcw_pkg::CH_NEWLINE, 11'd0);
    send_request(tcw_pkg::OP_READ, 8'h00, 11'd0);
    send_request(tcw_pkg::OP_READ, 8'h00, 11'd2);
    send_request(tcw_pkg::OP_READ, 8'h00, 11'd8);
    send_request(tcw_pkg::OP_CLEAR, 8'h00, 11'd0);
    send_request(tcw_pkg::OP_READ, 8'h00, 11'd1999);
    in_valid <= 1'b0;
    wait_drained();
    write_attribute(8'hFF);
    send_request(tcw_pkg::OP_PUT, 8'h5A, 11'd0);
    send_request(tcw_pkg::OP_READ, 8'h00, 11'd0);
    send_request(tcw_pkg::OP_READ, 8'h00, 11'd1);
    in_valid <= 1'b0;

    // random phases under different idling
    run_phase(0, 0, 8'h00);
    run_phase(80, 0, tcw_pkg::ATTR_W'($urandom_range(1, 254)));
    run_phase(0, 80, 8'hFF);
    run_phase(19, 19, tcw_pkg::ATTR_W'($urandom_range(255)));

    wait_drained();
    repeat (10) @(posedge clk);
    $display("%0d requests, %0d results checked; %0d scrolls, %0d clears, %0d reads",
             board.requests, board.results, board.scrolls, board.clears, board.reads);
    $display("%0d attribute settings, %0d failures", board.attr_writes, board.failures);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
